// ===== src/periodic_timer_table_core_macros.svh =====
// assertion macros for the periodic timer table
`ifndef PERIODIC_TIMER_TABLE_CORE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ptt_pkg.sv =====
// shared constants, codes and control structs of the periodic timer table
package ptt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_IW     = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CMD_W       = 2;
  localparam int KIND_W      = 3;
  localparam int CNT_W       = 7;
  localparam int TIME_W      = 48;
  localparam int HANDLE_W    = 32;
  localparam int IVL_W       = 32;
  localparam int RES_W       = 16;

  localparam logic [HANDLE_W-1:0] HANDLE_NONE  = '0;
  localparam logic [HANDLE_W-1:0] HANDLE_FIRST = HANDLE_W'(1);
  localparam logic [RES_W-1:0]    RES_RESET    = RES_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED    = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_CANCELED = 3'd2,
    KIND_FIRED    = 3'd3,
    KIND_NONE     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_ADVANCE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic add;
    logic advance;
    logic step;
    logic finish;
  } dp_ctl_t;

  typedef struct packed {
    logic push_ok;
    logic hold;
    logic scan_last;
  } dp_sts_t;

endpackage

// ===== src/ptt_ifs.sv =====
// channel interfaces: request, response and configuration write
interface ptt_req_if import ptt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [IVL_W-1:0]    interval_ms;
  logic [HANDLE_W-1:0] target_handle;

  modport source (output valid, cmd, interval_ms, target_handle, input ready);
  modport sink   (input valid, cmd, interval_ms, target_handle, output ready);
endinterface

interface ptt_rsp_if import ptt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic [HANDLE_W-1:0] result_handle;
  logic [CNT_W-1:0]    active_count;
  logic                last_result;

  modport source (output valid, result_kind, result_handle, active_count, last_result,
                  input ready);
  modport sink   (input valid, result_kind, result_handle, active_count, last_result,
                  output ready);
endinterface

interface ptt_cfg_if import ptt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] resolution_ms;

  modport source (output valid, resolution_ms, input ready);
  modport sink   (input valid, resolution_ms, output ready);
endinterface

// ===== src/periodic_timer_table_core.sv =====
// top level of the periodic timer table
//
// req carries one word per command: cmd 0 adds a timer with interval_ms,
// cmd 1 cancels target_handle, cmd 2 is a tick; cmd 3 is dropped silently.
// rsp returns result words; the last word caused by a command has
// last_result set and every word carries the active timer count.
// cfg writes resolution_ms, the time added per tick; it is always ready,
// and the user must write it only while no command is in flight, which
// the block itself does not enforce. An add is answered from ST_ADD
// through the response register; a cancel walks all 16 slots, one per
// cycle, and answers from ST_FINISH; a tick first advances time in
// ST_ADVANCE, then walks the slots and sends each fired handle in slot
// order, the last word from ST_FINISH. One command is handled at a time.
// reset clears all slots, sets time to zero, next handle to one and the
// resolution to one. a stalled rsp holds the response register and
// pauses the slot walk; req is taken again only after the last word is
// loaded into the response register.
module periodic_timer_table_core import ptt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ptt_req_if.sink   req,
  ptt_rsp_if.source rsp,
  ptt_cfg_if.sink   cfg
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  ptt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req_cmd      (req.cmd),
    .req_interval (req.interval_ms),
    .req_target   (req.target_handle),
    .cfg          (cfg),
    .rsp          (rsp),
    .ctl          (ctl),
    .sts          (sts)
  );

endmodule

// ===== src/ptt_ctrl.sv =====
// sequencer of the periodic timer table: add, cancel scan, tick scan
module ptt_ctrl import ptt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [CMD_W-1:0] req_cmd,
  output logic             req_ready,
  output dp_ctl_t          ctl,
  input  dp_sts_t          sts
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load = 1'b1;
          unique case (req_cmd)
            CMD_ADD:    state_next = ST_ADD;
            CMD_CANCEL: state_next = ST_SCAN;
            CMD_TICK:   state_next = ST_ADVANCE;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (sts.push_ok) begin
          ctl.add    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ADVANCE: begin
        ctl.advance = 1'b1;
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts.hold) begin
          ctl.step = 1'b1;
          if (sts.scan_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (sts.push_ok) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/ptt_datapath.sv =====
// slot table, time base, handle counter and response register
`include "periodic_timer_table_core_macros.svh"

module ptt_datapath import ptt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [CMD_W-1:0]    req_cmd,
  input  logic [IVL_W-1:0]    req_interval,
  input  logic [HANDLE_W-1:0] req_target,
  ptt_cfg_if.sink             cfg,
  ptt_rsp_if.source           rsp,
  input  dp_ctl_t             ctl,
  output dp_sts_t             sts
);

  logic [CMD_W-1:0]    op;
  logic [IVL_W-1:0]    ivl;
  logic [HANDLE_W-1:0] tgt;
  logic [SLOT_IW-1:0]  idx;
  logic [TIME_W-1:0]   cur_time;
  logic [HANDLE_W-1:0] nfh;
  logic [RES_W-1:0]    resolution;
  logic [TIMER_SLOTS-1:0] slot_valid;
  logic [HANDLE_W-1:0] slot_handle   [TIMER_SLOTS];
  logic [IVL_W-1:0]    slot_interval [TIMER_SLOTS];
  logic [TIME_W-1:0]   slot_deadline [TIMER_SLOTS];
  logic [CNT_W-1:0]    active_cnt;
  logic                pend_valid;
  logic [HANDLE_W-1:0] pend_handle;
  logic                out_valid;
  kind_t               out_kind;
  logic [HANDLE_W-1:0] out_handle;
  logic [CNT_W-1:0]    out_cnt;
  logic                out_last;

  logic                sel_hit;
  logic                sel_fire;
  logic [TIME_W-1:0]   rearm;
  logic                free_found;
  logic [SLOT_IW-1:0]  free_idx;
  logic                add_ok;
  logic                push_ok;
  logic [HANDLE_W-1:0] nfh_inc;
  logic [HANDLE_W-1:0] nfh_next;
  logic                push;
  kind_t               push_kind;
  logic [HANDLE_W-1:0] push_handle;
  logic [CNT_W-1:0]    push_cnt;
  logic                push_last;

  assign cfg.ready = 1'b1;

  assign rsp.valid         = out_valid;
  assign rsp.result_kind   = out_kind;
  assign rsp.result_handle = out_handle;
  assign rsp.active_count  = out_cnt;
  assign rsp.last_result   = out_last;

  assign sel_hit  = (op == CMD_CANCEL) && (tgt != HANDLE_NONE) && slot_valid[idx]
                    && (slot_handle[idx] == tgt);
  assign sel_fire = (op == CMD_TICK) && slot_valid[idx] && (cur_time >= slot_deadline[idx]);
  assign rearm    = cur_time + TIME_W'(slot_interval[idx]);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IW'(i);
      end
    end
  end

  assign add_ok   = (ivl != '0) && free_found;
  assign push_ok  = !out_valid || rsp.ready;
  assign nfh_inc  = nfh + HANDLE_W'(1);
  assign nfh_next = (nfh_inc == HANDLE_NONE) ? HANDLE_FIRST : nfh_inc;

  assign sts.push_ok   = push_ok;
  assign sts.hold      = sel_fire && pend_valid && !push_ok;
  assign sts.scan_last = (idx == SLOT_IW'(TIMER_SLOTS - 1));

  always_comb begin
    push        = 1'b0;
    push_kind   = KIND_NONE;
    push_handle = HANDLE_NONE;
    push_cnt    = active_cnt;
    push_last   = 1'b1;
    priority if (ctl.add) begin
      push = 1'b1;
      if (add_ok) begin
        push_kind   = KIND_ADDED;
        push_handle = nfh;
        push_cnt    = active_cnt + CNT_W'(1);
      end else begin
        push_kind = KIND_REJECTED;
      end
    end else if (ctl.step && sel_fire && pend_valid) begin
      // an earlier fired word goes out once a later one is known
      push        = 1'b1;
      push_kind   = KIND_FIRED;
      push_handle = pend_handle;
      push_last   = 1'b0;
    end else if (ctl.finish) begin
      push = 1'b1;
      if (op == CMD_CANCEL) begin
        push_kind = KIND_CANCELED;
      end else if (pend_valid) begin
        push_kind   = KIND_FIRED;
        push_handle = pend_handle;
      end else begin
        push_kind = KIND_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= RES_RESET;
      cur_time   <= '0;
      nfh        <= HANDLE_FIRST;
      slot_valid <= '0;
      active_cnt <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        resolution <= cfg.resolution_ms;
      end
      if (ctl.load) begin
        idx        <= '0;
        pend_valid <= 1'b0;
      end
      if (ctl.advance) begin
        cur_time <= cur_time + TIME_W'(resolution);
      end
      if (ctl.add && add_ok) begin
        slot_valid[free_idx] <= 1'b1;
        active_cnt           <= active_cnt + CNT_W'(1);
        nfh                  <= nfh_next;
      end
      if (ctl.step) begin
        idx <= idx + SLOT_IW'(1);
        if (sel_hit) begin
          slot_valid[idx] <= 1'b0;
          active_cnt      <= active_cnt - CNT_W'(1);
        end
        if (sel_fire) begin
          pend_valid <= 1'b1;
        end
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op  <= req_cmd;
      ivl <= req_interval;
      tgt <= req_target;
    end
    if (ctl.add && add_ok) begin
      slot_handle[free_idx]   <= nfh;
      slot_interval[free_idx] <= ivl;
      slot_deadline[free_idx] <= cur_time + TIME_W'(ivl);
    end
    if (ctl.step && sel_fire) begin
      slot_deadline[idx] <= rearm;
      pend_handle        <= slot_handle[idx];
    end
    if (push) begin
      out_kind   <= push_kind;
      out_handle <= push_handle;
      out_cnt    <= push_cnt;
      out_last   <= push_last;
    end
  end

  `PTT_ASSERT_NOW(a_count_matches, 1'b1, active_cnt == CNT_W'($countones(slot_valid)), "bad count")
  `PTT_ASSERT_NOW(a_handle_nonzero, 1'b1, nfh != HANDLE_NONE, "next handle is zero")
  `PTT_ASSERT_NOW(a_pend_only_tick, pend_valid, op == CMD_TICK, "pending word outside a tick")
  `PTT_ASSERT_NEXT(a_push_lands, push, out_valid && (out_last == $past(push_last)), "not held")

endmodule
